### design/bfr_pkg.sv
// Package for the binaural FIR renderer: shared codes, widths, the sequencer
// state type and the control structs passed between the sequencer and the MAC.
// No dependencies.
package bfr_pkg;

   localparam int INDEX_W    = 9;
   localparam int GAIN_W     = 16;
   localparam int ITD_W      = 6;
   localparam int EAR_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_FRAC  = 13;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   // Delayed-ear codes.
   localparam logic [EAR_W-1:0] EAR_NONE  = 2'd0;
   localparam logic [EAR_W-1:0] EAR_LEFT  = 2'd1;
   localparam logic [EAR_W-1:0] EAR_RIGHT = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PUSH,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic lag_ok;
   } mac_ctl_type;

   typedef struct packed {
      logic scale;
      logic push;
      logic fire;
   } phase_type;

endpackage

### design/bfr_if.sv
// Channel interfaces of the binaural FIR renderer: request, response and
// register write channels. Depends on bfr_pkg.
interface bfr_req_if #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 18
) ();
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic signed [SAMPLE_BITS-1:0]   sample_in;
   logic [bfr_pkg::INDEX_W-1:0]     coef_index;
   logic signed [COEF_BITS-1:0]     coef_left;
   logic signed [COEF_BITS-1:0]     coef_right;

   modport source (output valid, req_type, sample_in, coef_index, coef_left, coef_right,
                   input ready);
   modport sink   (input valid, req_type, sample_in, coef_index, coef_left, coef_right,
                   output ready);
endinterface

interface bfr_rsp_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface bfr_csr_if ();
   logic                               valid;
   logic                               ready;
   logic [bfr_pkg::CSR_IDX_W-1:0]      index;
   logic [bfr_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### design/binaural_fir_renderer.sv
// Binaural FIR renderer: mono samples in, left and right ear samples out.
// Request channel (req_bus): a load request writes one left/right tap pair at
// coef_index and gives no response; an audio request takes one mono sample.
// Response channel (rsp_bus): one left/right pair per audio request, in order.
// Register channel (csr_bus): always ready; index 0 distance gain (Q3.13),
// 1 interaural delay in samples, 2 delayed ear. Write it only while idle.
// Each audio sample is scaled by the gain, pushed into a TAPS-deep history and
// run through both FIRs on one shared dual multiply-accumulate unit, one tap
// per cycle. The chosen ear then passes through a MAX_DELAY-deep delay line.
// Timing: a load request is accepted while idle; an audio request passes
// through the scale, push, tap loop, drain and finish steps, and its
// response is shown as the block raises ready again, so no new sample is
// taken before then. A finished response waits in the output register while
// the next request is accepted; if it is still not taken when the following
// result is ready, the sequencer holds until the receiver takes it.
// Reset: history and delay line read as zero until written, gain is unity,
// no delay. Tap memories hold nothing defined until loaded; every tap index
// must be loaded before audio flows. No clearing pass is needed after reset.
module binaural_fir_renderer #(
   parameter int TAPS        = 512,
   parameter int MAX_DELAY   = 64,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 18
) (
   input  logic      clock,
   input  logic      reset,
   bfr_req_if.sink   req_bus,
   bfr_rsp_if.source rsp_bus,
   bfr_csr_if.sink   csr_bus
);

   localparam int AW     = $clog2(TAPS);
   localparam int DW     = $clog2(MAX_DELAY);
   localparam int GP_W   = SAMPLE_BITS + bfr_pkg::GAIN_W + 1;
   localparam int IDXC_W = ((bfr_pkg::INDEX_W > AW) ? bfr_pkg::INDEX_W : AW) + 1;
   localparam int DC_W   = ((DW > bfr_pkg::ITD_W) ? DW : bfr_pkg::ITD_W) + 1;
   localparam logic signed [GP_W:0] GAIN_HALF = (GP_W+1)'(1) <<< (bfr_pkg::GAIN_FRAC - 1);
   localparam logic signed [GP_W:0] SAT_HI =
      {{(GP_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [GP_W:0] SAT_LO = ~SAT_HI;
   localparam logic [DC_W-1:0] DMAX = DC_W'(MAX_DELAY - 1);
   localparam logic [DW:0]     DFULL = (DW+1)'(MAX_DELAY);

   // Configuration registers.
   logic [bfr_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [bfr_pkg::ITD_W-1:0]  itd_ff, itd_in;
   logic [bfr_pkg::EAR_W-1:0]  ear_ff, ear_in;

   logic                          req_fire, start, out_free, mac_busy;
   logic                          coef_we;
   logic                          hist_we, hist_re;
   logic [AW-1:0]                 hist_waddr, hist_raddr, coef_raddr, coef_waddr;
   bfr_pkg::mac_ctl_type          mac_ctl;
   bfr_pkg::phase_type            phase;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [GP_W-1:0]        gprod_ff, gprod_in;
   logic signed [GP_W:0]          grnd, gshf, gsat;
   logic signed [SAMPLE_BITS-1:0] scaled;

   logic [SAMPLE_BITS-1:0]        hist_rd;
   logic [2*COEF_BITS-1:0]        coef_rd;
   logic signed [SAMPLE_BITS-1:0] fir_l, fir_r;

   logic [DW-1:0]                 dp_ff, dp_in, d_eff, dly_raddr;
   logic [DW:0]                   dfill_ff, dfill_in, dwrap;
   logic [SAMPLE_BITS-1:0]        dly_rd;
   logic signed [SAMPLE_BITS-1:0] pre, delayed, left_val, right_val;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;

   assign req_fire = req_bus.valid & req_bus.ready;
   assign start    = req_fire & (req_bus.req_type == bfr_pkg::REQ_SAMPLE);
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   // Loads beyond the tap count are dropped.
   assign coef_we    = req_fire & (req_bus.req_type == bfr_pkg::REQ_LOAD) &
                       (IDXC_W'(req_bus.coef_index) < IDXC_W'(TAPS));
   assign coef_waddr = AW'(req_bus.coef_index);

   assign csr_bus.ready = 1'b1;

   always_comb begin
      gain_in = gain_ff;
      itd_in  = itd_ff;
      ear_in  = ear_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            bfr_pkg::CSR_GAIN: gain_in = csr_bus.wdata[bfr_pkg::GAIN_W-1:0];
            bfr_pkg::CSR_ITD:  itd_in  = csr_bus.wdata[bfr_pkg::ITD_W-1:0];
            bfr_pkg::CSR_EAR:  ear_in  = csr_bus.wdata[bfr_pkg::EAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bfr_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .out_free   (out_free),
      .mac_busy   (mac_busy),
      .in_ready   (req_bus.ready),
      .hist_we    (hist_we),
      .hist_waddr (hist_waddr),
      .hist_re    (hist_re),
      .hist_raddr (hist_raddr),
      .coef_raddr (coef_raddr),
      .mac_ctl    (mac_ctl),
      .phase      (phase)
   );

   // Distance gain: product rounded half up by the Q3.13 fraction, saturated.
   always_comb begin
      gprod_in = GP_W'(sample_ff) * GP_W'($signed({1'b0, gain_ff}));
      grnd     = (GP_W+1)'(gprod_ff) + GAIN_HALF;
      gshf     = grnd >>> bfr_pkg::GAIN_FRAC;
      if (gshf > SAT_HI) begin
         gsat = SAT_HI;
      end else if (gshf < SAT_LO) begin
         gsat = SAT_LO;
      end else begin
         gsat = gshf;
      end
      scaled = gsat[SAMPLE_BITS-1:0];
   end

   bfr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (scaled),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   bfr_ram #(
      .WIDTH (2 * COEF_BITS),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data ({req_bus.coef_left, req_bus.coef_right}),
      .rd_en   (hist_re),
      .rd_addr (coef_raddr),
      .rd_data (coef_rd)
   );

   bfr_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .hist_data ($signed(hist_rd)),
      .coef_l    ($signed(coef_rd[2*COEF_BITS-1:COEF_BITS])),
      .coef_r    ($signed(coef_rd[COEF_BITS-1:0])),
      .busy      (mac_busy),
      .left_res  (fir_l),
      .right_res (fir_r)
   );

   // Interaural delay: the entry is read when the sample is pushed into the history
   // and the new value is written when the result is handed to the output register.
   always_comb begin
      d_eff     = (DC_W'(itd_ff) > DMAX) ? DW'(DMAX) : DW'(itd_ff);
      dwrap     = {1'b0, dp_ff} + DFULL - {1'b0, d_eff};
      dly_raddr = (dp_ff >= d_eff) ? dp_ff - d_eff : dwrap[DW-1:0];
      case (ear_ff)
         bfr_pkg::EAR_LEFT:  pre = fir_l;
         bfr_pkg::EAR_RIGHT: pre = fir_r;
         default:            pre = '0;
      endcase
      if (d_eff == '0) begin
         delayed = pre;
      end else if (dfill_ff >= {1'b0, d_eff}) begin
         delayed = $signed(dly_rd);
      end else begin
         delayed = '0;
      end
      left_val  = (ear_ff == bfr_pkg::EAR_LEFT)  ? delayed : fir_l;
      right_val = (ear_ff == bfr_pkg::EAR_RIGHT) ? delayed : fir_r;
      dp_in     = dp_ff;
      dfill_in  = dfill_ff;
      if (phase.fire) begin
         dp_in    = (dp_ff == DW'(MAX_DELAY - 1)) ? '0 : dp_ff + 1'b1;
         dfill_in = (dfill_ff == DFULL) ? DFULL : dfill_ff + 1'b1;
      end
   end

   bfr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (phase.fire),
      .wr_addr (dp_ff),
      .wr_data (pre),
      .rd_en   (phase.push),
      .rd_addr (dly_raddr),
      .rd_data (dly_rd)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (phase.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= bfr_pkg::GAIN_RESET;
         itd_ff       <= '0;
         ear_ff       <= bfr_pkg::EAR_NONE;
         dp_ff        <= '0;
         dfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         itd_ff       <= itd_in;
         ear_ff       <= ear_in;
         dp_ff        <= dp_in;
         dfill_ff     <= dfill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (start) begin
         sample_ff <= req_bus.sample_in;
      end
      if (phase.scale) begin
         gprod_ff <= gprod_in;
      end
      if (phase.fire) begin
         left_ff  <= left_val;
         right_ff <= right_val;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_ff;
   assign rsp_bus.right_out = right_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase.fire))
      else $error("response raised without a finished sample");

   a_idle_mac_quiet: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !mac_busy)
      else $error("request port ready while the tap loop is still running");

   a_push_then_taps: assert property (@(posedge clock) disable iff (reset)
      phase.push |=> (hist_re && mac_ctl.issue))
      else $error("tap loop did not follow the history write");

   a_fire_after_drain: assert property (@(posedge clock) disable iff (reset)
      phase.fire |-> (!mac_busy && !hist_re))
      else $error("result handed over before the accumulators settled");
`endif

endmodule

### design/bfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bfr_mac.sv
// Dual multiply-accumulate unit shared by all taps: one left and one right
// product per cycle, then a rounded, saturated result per ear. Depends on bfr_pkg.
module bfr_mac #(
   parameter int TAPS        = 512,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfr_pkg::mac_ctl_type          ctl,
   input  logic signed [SAMPLE_BITS-1:0] hist_data,
   input  logic signed [COEF_BITS-1:0]   coef_l,
   input  logic signed [COEF_BITS-1:0]   coef_r,
   output logic                          busy,
   output logic signed [SAMPLE_BITS-1:0] left_res,
   output logic signed [SAMPLE_BITS-1:0] right_res
);

   localparam int PW    = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W = PW + $clog2(TAPS);
   localparam int FRAC  = COEF_BITS - 2;
   localparam logic signed [ACC_W:0] HALF   = (ACC_W+1)'(1) <<< (FRAC - 1);
   localparam logic signed [ACC_W:0] SAT_HI =
      {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

   logic                    iss_ff, pv_ff, lagok_ff;
   logic signed [PW-1:0]    prod_l_ff, prod_r_ff, prod_l_in, prod_r_in;
   logic signed [ACC_W-1:0] acc_l_ff, acc_r_ff, acc_l_in, acc_r_in;

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0] rnd;
      logic signed [ACC_W:0] shf;
      logic signed [ACC_W:0] sat;
      rnd = (ACC_W+1)'(acc) + HALF;
      shf = rnd >>> FRAC;
      if (shf > SAT_HI) begin
         sat = SAT_HI;
      end else if (shf < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = shf;
      end
      return sat[SAMPLE_BITS-1:0];
   endfunction

   // Lags older than the history fill contribute zero.
   always_comb begin
      prod_l_in = lagok_ff ? PW'(hist_data) * PW'(coef_l) : '0;
      prod_r_in = lagok_ff ? PW'(hist_data) * PW'(coef_r) : '0;
      acc_l_in  = acc_l_ff;
      acc_r_in  = acc_r_ff;
      if (ctl.clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (pv_ff) begin
         acc_l_in = acc_l_ff + ACC_W'(prod_l_ff);
         acc_r_in = acc_r_ff + ACC_W'(prod_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0;
         pv_ff  <= 1'b0;
      end else begin
         iss_ff <= ctl.issue;
         pv_ff  <= iss_ff;
      end
      lagok_ff <= ctl.lag_ok;
      if (iss_ff) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
   end

   assign busy      = iss_ff | pv_ff;
   assign left_res  = round_sat(acc_l_ff);
   assign right_res = round_sat(acc_r_ff);

endmodule

### design/bfr_ctrl.sv
// Sequencer of the binaural FIR renderer: history pointers, the tap loop that
// drives the shared MAC, and the phase strobes. Depends on bfr_pkg.
module bfr_ctrl #(
   parameter int TAPS = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        out_free,
   input  logic                        mac_busy,
   output logic                        in_ready,
   output logic                        hist_we,
   output logic [$clog2(TAPS)-1:0]     hist_waddr,
   output logic                        hist_re,
   output logic [$clog2(TAPS)-1:0]     hist_raddr,
   output logic [$clog2(TAPS)-1:0]     coef_raddr,
   output bfr_pkg::mac_ctl_type        mac_ctl,
   output bfr_pkg::phase_type          phase
);

   localparam int AW = $clog2(TAPS);
   localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
   localparam logic [AW:0]   FULL = (AW+1)'(TAPS);

   bfr_pkg::ctrl_state_type state_ff, state_in;
   logic [AW-1:0] hp_ff, hp_in, rp_ff, rp_in, k_ff, k_in;
   logic [AW:0]   hfill_ff, hfill_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfr_pkg::ST_IDLE:   if (start) state_in = bfr_pkg::ST_SCALE;
         bfr_pkg::ST_SCALE:  state_in = bfr_pkg::ST_PUSH;
         bfr_pkg::ST_PUSH:   state_in = bfr_pkg::ST_MAC;
         bfr_pkg::ST_MAC:    if (k_ff == LAST) state_in = bfr_pkg::ST_DRAIN;
         bfr_pkg::ST_DRAIN:  if (!mac_busy) state_in = bfr_pkg::ST_FINISH;
         bfr_pkg::ST_FINISH: if (out_free) state_in = bfr_pkg::ST_IDLE;
         default:            state_in = bfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready   = 1'b0;
      hist_we    = 1'b0;
      hist_waddr = hp_ff;
      hist_re    = 1'b0;
      hist_raddr = rp_ff;
      coef_raddr = k_ff;
      mac_ctl    = '0;
      phase      = '0;
      hp_in      = hp_ff;
      rp_in      = rp_ff;
      k_in       = k_ff;
      hfill_in   = hfill_ff;
      case (state_ff)
         bfr_pkg::ST_IDLE: begin
            in_ready = 1'b1;
         end
         bfr_pkg::ST_SCALE: begin
            phase.scale = 1'b1;
         end
         bfr_pkg::ST_PUSH: begin
            phase.push    = 1'b1;
            hist_we       = 1'b1;
            mac_ctl.clear = 1'b1;
            rp_in         = hp_ff;
            k_in          = '0;
            hp_in         = (hp_ff == LAST) ? '0 : hp_ff + 1'b1;
            hfill_in      = (hfill_ff == FULL) ? FULL : hfill_ff + 1'b1;
         end
         bfr_pkg::ST_MAC: begin
            // The newest sample meets tap 0; the read pointer walks backward.
            hist_re        = 1'b1;
            mac_ctl.issue  = 1'b1;
            mac_ctl.lag_ok = {1'b0, k_ff} < hfill_ff;
            rp_in          = (rp_ff == '0) ? LAST : rp_ff - 1'b1;
            k_in           = k_ff + 1'b1;
         end
         bfr_pkg::ST_DRAIN: begin
         end
         bfr_pkg::ST_FINISH: begin
            phase.fire = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfr_pkg::ST_IDLE;
         hp_ff    <= '0;
         hfill_ff <= '0;
      end else begin
         state_ff <= state_in;
         hp_ff    <= hp_in;
         hfill_ff <= hfill_in;
      end
      rp_ff <= rp_in;
      k_ff  <= k_in;
   end

endmodule
